// ----- src/clipped_rect_fill_lut_engine_core_macros.svh -----
// Assertion helpers, used by the engine's back module.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CLIPPED_RECT_FILL_LUT_ENGINE_CORE_MACROS_SVH
`define CLIPPED_RECT_FILL_LUT_ENGINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/crf_pkg.sv -----
package crf_pkg;

	// Coordinate width covers every panel size up to 1024.
	localparam int COORD_W = 11;
	localparam int PANEL_WIDTH_DEF = 640;
	localparam int PANEL_HEIGHT_DEF = 480;
	localparam int QUEUE_DEPTH = 4;

	// Operation codes.
	localparam logic [2:0] OP_SET_CLIP = 3'd0;
	localparam logic [2:0] OP_FILL = 3'd1;
	localparam logic [2:0] OP_REMAP = 3'd2;
	localparam logic [2:0] OP_READ = 3'd3;
	localparam logic [2:0] OP_CLEAR_CLIP = 3'd4;

	// Status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_BATCH = 3'd1;
	localparam logic [2:0] ST_NO_LEASE = 3'd2;
	localparam logic [2:0] ST_NOT_ARMED = 3'd3;
	localparam logic [2:0] ST_BOUNDS = 3'd4;
	localparam logic [2:0] ST_VALUE = 3'd5;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_FILL,
		JOB_REMAP,
		JOB_READ
	} job_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		job_t job;
		logic [2:0] status;
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		logic [3:0] level;
		logic [63:0] lut;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic dirty_valid;
		logic [9:0] dirty_left;
		logic [8:0] dirty_top;
		logic [9:0] dirty_width;
		logic [8:0] dirty_height;
		logic [3:0] pixel_value;
	} result_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SETUP,
		BK_RD,
		BK_WR,
		BK_READ_WAIT,
		BK_DONE
	} back_state_t;

endpackage

// ----- src/crf_front.sv -----
module crf_front import crf_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] operation,
	input logic in_batch,
	input logic lease_active,
	input logic [15:0] rect_left,
	input logic [15:0] rect_top,
	input logic [15:0] rect_width,
	input logic [15:0] rect_height,
	input logic [7:0] fill_level,
	input logic [63:0] remap_table,
	input logic draw2_armed_we,
	input logic draw2_armed_wdata,
	input logic clearing,
	output cmd_t cmd,
	output logic cmd_valid,
	input logic cmd_ready
);

	localparam logic [16:0] PW = 17'(PANEL_WIDTH);
	localparam logic [16:0] PH = 17'(PANEL_HEIGHT);

	logic armed_q;
	logic valid_s1;
	logic [2:0] op_s1;
	logic batch_s1;
	logic lease_s1;
	logic [15:0] l_s1;
	logic [15:0] t_s1;
	logic [15:0] w_s1;
	logic [15:0] h_s1;
	logic [7:0] level_s1;
	logic [63:0] lut_s1;
	logic clip_en_q;
	coord_t clip_l_q;
	coord_t clip_t_q;
	coord_t clip_r_q;
	coord_t clip_b_q;
	logic accept;
	logic fire;
	logic [16:0] sum_x;
	logic [16:0] sum_y;
	logic rect_bad;
	logic read_bad;
	coord_t cl;
	coord_t ct;
	coord_t cr;
	coord_t cb;
	logic [16:0] x0;
	logic [16:0] y0;
	logic [16:0] x1;
	logic [16:0] y1;
	logic nonempty;
	logic set_clip;
	logic clear_clip;

	assign full = clearing || (valid_s1 && !cmd_ready);
	assign accept = push && !full;
	assign fire = valid_s1 && cmd_ready;
	assign cmd_valid = valid_s1;

	// Session arming register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (draw2_armed_we) begin
			armed_q <= draw2_armed_wdata;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= operation;
			batch_s1 <= in_batch;
			lease_s1 <= lease_active;
			l_s1 <= rect_left;
			t_s1 <= rect_top;
			w_s1 <= rect_width;
			h_s1 <= rect_height;
			level_s1 <= fill_level;
			lut_s1 <= remap_table;
		end
	end

	// Bounds and clip cut.
	always_comb begin
		sum_x = {1'b0, l_s1} + {1'b0, w_s1};
		sum_y = {1'b0, t_s1} + {1'b0, h_s1};
		rect_bad = (w_s1 == 16'd0) || (h_s1 == 16'd0) || (sum_x > PW) || (sum_y > PH);
		read_bad = ({1'b0, l_s1} >= PW) || ({1'b0, t_s1} >= PH);
		cl = clip_en_q ? clip_l_q : '0;
		ct = clip_en_q ? clip_t_q : '0;
		cr = clip_en_q ? clip_r_q : COORD_W'(PANEL_WIDTH);
		cb = clip_en_q ? clip_b_q : COORD_W'(PANEL_HEIGHT);
		x0 = ({1'b0, l_s1} < 17'(cl)) ? 17'(cl) : {1'b0, l_s1};
		y0 = ({1'b0, t_s1} < 17'(ct)) ? 17'(ct) : {1'b0, t_s1};
		x1 = (sum_x > 17'(cr)) ? 17'(cr) : sum_x;
		y1 = (sum_y > 17'(cb)) ? 17'(cb) : sum_y;
		nonempty = (x0 < x1) && (y0 < y1);
	end

	// Classification in the model's check order.
	always_comb begin
		cmd = '0;
		cmd.job = JOB_NONE;
		cmd.status = ST_OK;
		cmd.x0 = x0[COORD_W-1:0];
		cmd.y0 = y0[COORD_W-1:0];
		cmd.x1 = x1[COORD_W-1:0];
		cmd.y1 = y1[COORD_W-1:0];
		cmd.level = level_s1[3:0];
		cmd.lut = lut_s1;
		set_clip = 1'b0;
		clear_clip = 1'b0;
		priority if (op_s1 == OP_CLEAR_CLIP) begin
			clear_clip = 1'b1;
		end else if (op_s1 > OP_CLEAR_CLIP) begin
			cmd.status = ST_VALUE;
		end else if (op_s1 == OP_SET_CLIP && !batch_s1) begin
			cmd.status = ST_NO_BATCH;
		end else if (!lease_s1) begin
			cmd.status = ST_NO_LEASE;
		end else if (!armed_q) begin
			cmd.status = ST_NOT_ARMED;
		end else if (op_s1 == OP_READ) begin
			if (read_bad) begin
				cmd.status = ST_BOUNDS;
			end else begin
				cmd.job = JOB_READ;
				cmd.x0 = l_s1[COORD_W-1:0];
				cmd.y0 = t_s1[COORD_W-1:0];
			end
		end else if (rect_bad) begin
			cmd.status = ST_BOUNDS;
		end else if (op_s1 == OP_SET_CLIP) begin
			set_clip = 1'b1;
		end else if (op_s1 == OP_FILL && level_s1 > 8'd15) begin
			cmd.status = ST_VALUE;
		end else if (nonempty) begin
			cmd.job = (op_s1 == OP_FILL) ? JOB_FILL : JOB_REMAP;
		end else begin
			// Rectangle wholly outside the clip: nothing to walk.
			cmd.job = JOB_NONE;
		end
	end

	// Clip state follows each command as it leaves the front.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_en_q <= 1'b0;
			clip_l_q <= '0;
			clip_t_q <= '0;
			clip_r_q <= '0;
			clip_b_q <= '0;
		end else if (fire) begin
			if (clear_clip) begin
				clip_en_q <= 1'b0;
			end else if (set_clip) begin
				clip_en_q <= 1'b1;
				clip_l_q <= l_s1[COORD_W-1:0];
				clip_t_q <= t_s1[COORD_W-1:0];
				clip_r_q <= sum_x[COORD_W-1:0];
				clip_b_q <= sum_y[COORD_W-1:0];
			end
		end
	end

endmodule

// ----- src/crf_cmd_fifo.sv -----
module crf_cmd_fifo import crf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input cmd_t wr_data,
	output logic rd_valid,
	input logic rd_pop,
	output cmd_t rd_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_pop && rd_valid;
	assign rd_data = slots_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- src/crf_back.sv -----
`include "clipped_rect_fill_lut_engine_core_macros.svh"

module crf_back import crf_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	output logic clearing,
	output result_t result,
	output logic empty,
	input logic pop
);

	localparam int ROW_BYTES = (PANEL_WIDTH + 1) / 2;
	localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
	localparam int AW = $clog2(STORE_BYTES);

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;
	back_state_t state_q;
	back_state_t state_d;
	cmd_t cmd_q;
	coord_t x_q;
	coord_t y_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] clr_q;
	logic [3:0] pv_q;
	result_t res_q;
	logic res_valid_q;
	logic [AW-1:0] addr;
	logic [3:0] pix;
	logic [3:0] new_pix;
	logic [7:0] wdata;
	logic we;
	logic load_res;
	logic last_x;
	logic last_y;
	result_t res_d;

	assign addr = base_q + AW'(x_q[COORD_W-1:1]);
	assign pix = x_q[0] ? rdata_q[3:0] : rdata_q[7:4];
	assign new_pix = (cmd_q.job == JOB_FILL) ? cmd_q.level : cmd_q.lut[{~pix, 2'b00} +: 4];
	assign wdata = x_q[0] ? {rdata_q[7:4], new_pix} : {new_pix, rdata_q[3:0]};
	assign last_x = (x_q + 1'b1) >= cmd_q.x1;
	assign last_y = (y_q + 1'b1) >= cmd_q.y1;
	assign clearing = (state_q == BK_CLEAR);
	assign empty = !res_valid_q;
	assign result = res_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		we = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				we = 1'b1;
				if (clr_q == AW'(STORE_BYTES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (cmd.job == JOB_NONE) ? BK_DONE : BK_SETUP;
				end
			end
			BK_SETUP: state_d = BK_RD;
			BK_RD: state_d = (cmd_q.job == JOB_READ) ? BK_READ_WAIT : BK_WR;
			BK_WR: begin
				we = 1'b1;
				state_d = (last_x && last_y) ? BK_DONE : BK_RD;
			end
			BK_READ_WAIT: state_d = BK_DONE;
			BK_DONE: begin
				if (!res_valid_q || pop) begin
					load_res = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Walk registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == BK_SETUP) begin
			base_q <= AW'(cmd_q.y0 * ROW_BYTES);
			x_q <= cmd_q.x0;
			y_q <= cmd_q.y0;
		end else if (state_q == BK_WR && !last_x) begin
			x_q <= x_q + 1'b1;
		end else if (state_q == BK_WR) begin
			x_q <= cmd_q.x0;
			y_q <= y_q + 1'b1;
			base_q <= base_q + AW'(ROW_BYTES);
		end
		if (state_q == BK_READ_WAIT) begin
			pv_q <= pix;
		end
	end

	// Frame store.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[clearing ? clr_q : addr] <= clearing ? 8'h00 : wdata;
		end
		rdata_q <= mem[addr];
	end

	// Result word.
	always_comb begin
		res_d = '0;
		res_d.status = cmd_q.status;
		if (cmd_q.job == JOB_FILL || cmd_q.job == JOB_REMAP) begin
			res_d.dirty_valid = 1'b1;
			res_d.dirty_left = cmd_q.x0[9:0];
			res_d.dirty_top = cmd_q.y0[8:0];
			res_d.dirty_width = 10'(cmd_q.x1 - cmd_q.x0);
			res_d.dirty_height = 9'(cmd_q.y1 - cmd_q.y0);
		end
		if (cmd_q.job == JOB_READ) begin
			res_d.pixel_value = pv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
	end

	`CRF_ASSERT_NOW(a_write_phase, we, state_q == BK_WR || state_q == BK_CLEAR, "store written outside a write phase")
	`CRF_ASSERT_NOW(a_wr_after_rd, state_q == BK_WR, $past(state_q) == BK_RD, "write phase without a preceding read")
	`CRF_ASSERT_NOW(a_no_result_in_clear, clearing, !res_valid_q, "result present during clearing pass")
	`CRF_ASSERT_NEXT(a_res_held, res_valid_q && !pop, res_valid_q && $stable(res_q), "waiting result word changed")

endmodule

// ----- src/clipped_rect_fill_lut_engine_core.sv -----
// Channel   Handshake            Payload
// command   push / full          operation .. remap_table
// result    pop / empty          status .. pixel_value
// config    draw2_armed_we       draw2_armed_wdata
//
// After reset the frame store, ((PANEL_WIDTH+1)/2)*PANEL_HEIGHT bytes (153600 at defaults),
// is swept to zero, one byte a cycle; full is high meanwhile.
// A fill or remap word comes back after a read-modify-write of the frame store per touched
// pixel (a read state, then a write state); refused and clip commands skip the walk and
// go straight to the result state, a pixel read through setup, read and read-wait states.
// The front keeps taking commands into a four-deep queue while the back walks the store.
module clipped_rect_fill_lut_engine_core import crf_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] operation,
	input logic in_batch,
	input logic lease_active,
	input logic [15:0] rect_left,
	input logic [15:0] rect_top,
	input logic [15:0] rect_width,
	input logic [15:0] rect_height,
	input logic [7:0] fill_level,
	input logic [63:0] remap_table,
	output logic empty,
	input logic pop,
	output logic [2:0] status,
	output logic dirty_valid,
	output logic [9:0] dirty_left,
	output logic [8:0] dirty_top,
	output logic [9:0] dirty_width,
	output logic [8:0] dirty_height,
	output logic [3:0] pixel_value,
	input logic draw2_armed_we,
	input logic draw2_armed_wdata
);

	cmd_t f_cmd;
	logic f_valid;
	logic f_ready;
	cmd_t q_cmd;
	logic q_valid;
	logic q_pop;
	logic clearing;
	result_t result;

	crf_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.operation(operation), .in_batch(in_batch), .lease_active(lease_active),
		.rect_left(rect_left), .rect_top(rect_top), .rect_width(rect_width),
		.rect_height(rect_height), .fill_level(fill_level), .remap_table(remap_table),
		.draw2_armed_we(draw2_armed_we), .draw2_armed_wdata(draw2_armed_wdata),
		.clearing(clearing), .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	crf_cmd_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_cmd), .rd_valid(q_valid), .rd_pop(q_pop), .rd_data(q_cmd)
	);

	crf_back #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop),
		.clearing(clearing), .result(result), .empty(empty), .pop(pop)
	);

	assign status = result.status;
	assign dirty_valid = result.dirty_valid;
	assign dirty_left = result.dirty_left;
	assign dirty_top = result.dirty_top;
	assign dirty_width = result.dirty_width;
	assign dirty_height = result.dirty_height;
	assign pixel_value = result.pixel_value;

endmodule

// ----- tb/clipped_rect_fill_lut_engine_checker.sv -----
// Watches the command, result and arming channels, keeps its own copy of the frame store
// and the clip, and compares every result word with the predicted one.
module clipped_rect_fill_lut_engine_checker import crf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [2:0] operation,
	input logic in_batch,
	input logic lease_active,
	input logic [15:0] rect_left,
	input logic [15:0] rect_top,
	input logic [15:0] rect_width,
	input logic [15:0] rect_height,
	input logic [7:0] fill_level,
	input logic [63:0] remap_table,
	input logic empty,
	input logic pop,
	input logic [2:0] status,
	input logic dirty_valid,
	input logic [9:0] dirty_left,
	input logic [8:0] dirty_top,
	input logic [9:0] dirty_width,
	input logic [8:0] dirty_height,
	input logic [3:0] pixel_value,
	input logic draw2_armed_we,
	input logic draw2_armed_wdata,
	output int fail_count,
	output int pending
);

	localparam int PW = PANEL_WIDTH_DEF;
	localparam int PH = PANEL_HEIGHT_DEF;

	// Shadow of the panel, one level per pixel, and of the clip and arming state.
	logic [3:0] shadow_pixels [0:PW*PH-1];
	logic armed;
	logic clip_on;
	int clip_l, clip_t, clip_r, clip_b;
	result_t awaited_results [$];

	// Applies one command to the shadow state and returns the word it should produce.
	function automatic result_t apply_command(input logic [2:0] op, input logic batch,
			input logic lease, input int l, input int t, input int w, input int h,
			input int lvl, input logic [63:0] lut_word);
		result_t r;
		int x0, y0, x1, y1, cl, ct, cr, cb, x, y, p;
		r = '0;
		if (op == OP_CLEAR_CLIP) begin
			clip_on = 1'b0;
		end else if (op > OP_CLEAR_CLIP) begin
			r.status = ST_VALUE;
		end else if (op == OP_SET_CLIP && !batch) begin
			r.status = ST_NO_BATCH;
		end else if (!lease) begin
			r.status = ST_NO_LEASE;
		end else if (!armed) begin
			r.status = ST_NOT_ARMED;
		end else if (op == OP_READ) begin
			if (l >= PW || t >= PH) r.status = ST_BOUNDS;
			else r.pixel_value = shadow_pixels[t*PW + l];
		end else if (w == 0 || h == 0 || l + w > PW || t + h > PH) begin
			r.status = ST_BOUNDS;
		end else if (op == OP_SET_CLIP) begin
			clip_on = 1'b1;
			clip_l = l;
			clip_t = t;
			clip_r = l + w;
			clip_b = t + h;
		end else if (op == OP_FILL && lvl > 15) begin
			r.status = ST_VALUE;
		end else begin
			// Cut the rectangle to the panel and, when enabled, to the clip.
			cl = 0;
			ct = 0;
			cr = PW;
			cb = PH;
			if (clip_on) begin
				if (clip_l > cl) cl = clip_l;
				if (clip_t > ct) ct = clip_t;
				if (clip_r < cr) cr = clip_r;
				if (clip_b < cb) cb = clip_b;
			end
			x0 = (l < cl) ? cl : l;
			y0 = (t < ct) ? ct : t;
			x1 = (l + w > cr) ? cr : l + w;
			y1 = (t + h > cb) ? cb : t + h;
			if (x0 < x1 && y0 < y1) begin
				for (y = y0; y < y1; y++) begin
					for (x = x0; x < x1; x++) begin
						if (op == OP_FILL) begin
							shadow_pixels[y*PW + x] = lvl[3:0];
						end else begin
							p = shadow_pixels[y*PW + x];
							shadow_pixels[y*PW + x] = lut_word[63 - 4*p -: 4];
						end
					end
				end
				r.dirty_valid = 1'b1;
				r.dirty_left = x0[9:0];
				r.dirty_top = y0[8:0];
				r.dirty_width = 10'(x1 - x0);
				r.dirty_height = 9'(y1 - y0);
			end
		end
		return r;
	endfunction

	// Prediction on accepted commands, comparison on accepted result words.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < PW*PH; i++) shadow_pixels[i] = 4'd0;
			armed = 1'b0;
			clip_on = 1'b0;
			clip_l = 0;
			clip_t = 0;
			clip_r = 0;
			clip_b = 0;
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					$error("result word with nothing outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (dirty_valid !== want.dirty_valid) begin
						$error("dirty_valid: expected %0d, got %0d", want.dirty_valid,
							dirty_valid);
						fail_count++;
					end
					if (dirty_left !== want.dirty_left) begin
						$error("dirty_left: expected %0d, got %0d", want.dirty_left,
							dirty_left);
						fail_count++;
					end
					if (dirty_top !== want.dirty_top) begin
						$error("dirty_top: expected %0d, got %0d", want.dirty_top, dirty_top);
						fail_count++;
					end
					if (dirty_width !== want.dirty_width) begin
						$error("dirty_width: expected %0d, got %0d", want.dirty_width,
							dirty_width);
						fail_count++;
					end
					if (dirty_height !== want.dirty_height) begin
						$error("dirty_height: expected %0d, got %0d", want.dirty_height,
							dirty_height);
						fail_count++;
					end
					if (pixel_value !== want.pixel_value) begin
						$error("pixel_value: expected %0d, got %0d", want.pixel_value,
							pixel_value);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				awaited_results.push_back(apply_command(operation, in_batch, lease_active,
					int'(rect_left), int'(rect_top), int'(rect_width), int'(rect_height),
					int'(fill_level), remap_table));
			end
			if (draw2_armed_we) armed = draw2_armed_wdata;
			pending = awaited_results.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
module testbench;
	import crf_pkg::*;

	localparam int STALL_LIMIT = 2000000;
	localparam int RANDOM_WORDS = 560;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] operation = '0;
	logic in_batch = 1'b0;
	logic lease_active = 1'b0;
	logic [15:0] rect_left = '0;
	logic [15:0] rect_top = '0;
	logic [15:0] rect_width = '0;
	logic [15:0] rect_height = '0;
	logic [7:0] fill_level = '0;
	logic [63:0] remap_table = '0;
	logic empty;
	logic pop = 1'b0;
	logic [2:0] status;
	logic dirty_valid;
	logic [9:0] dirty_left;
	logic [8:0] dirty_top;
	logic [9:0] dirty_width;
	logic [8:0] dirty_height;
	logic [3:0] pixel_value;
	logic draw2_armed_we = 1'b0;
	logic draw2_armed_wdata = 1'b0;
	int fail_count;
	int pending;
	int accepted_words = 0;
	int stall_cycles = 0;
	logic no_gaps;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	clipped_rect_fill_lut_engine_core uut (.*);
	clipped_rect_fill_lut_engine_checker checker_inst (.*);

	// Both sides run without gaps for a stretch in the middle of the run.
	assign no_gaps = accepted_words >= 200 && accepted_words < 300;

	// Offers the word on the command ports, with random idle cycles first, until taken.
	task automatic offer_word();
		logic taken;
		while (!no_gaps && $urandom_range(99) < 19) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		do begin
			taken = !full;
			@(negedge clk);
		end while (!taken);
		accepted_words++;
	endtask

	task automatic issue(input logic [2:0] op, input logic batch, input logic lease,
			input int l, input int t, input int w, input int h, input int lvl,
			input logic [63:0] lut_word);
		operation = op;
		in_batch = batch;
		lease_active = lease;
		rect_left = l[15:0];
		rect_top = t[15:0];
		rect_width = w[15:0];
		rect_height = h[15:0];
		fill_level = lvl[7:0];
		remap_table = lut_word;
		offer_word();
	endtask

	// Waits until every result word has come back.
	task automatic drain();
		push = 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_armed(input logic v);
		drain();
		draw2_armed_we = 1'b1;
		draw2_armed_wdata = v;
		@(negedge clk);
		draw2_armed_we = 1'b0;
	endtask

	// Random command, mostly well formed and mostly in a small corner so reads hit
	// pixels that earlier fills and remaps have touched.
	task automatic issue_random();
		int sel, l, t, w, h, lvl;
		logic [2:0] op;
		sel = $urandom_range(99);
		if (sel < 10) op = OP_SET_CLIP;
		else if (sel < 40) op = OP_FILL;
		else if (sel < 65) op = OP_REMAP;
		else if (sel < 85) op = OP_READ;
		else if (sel < 93) op = OP_CLEAR_CLIP;
		else op = 3'($urandom_range(5, 7));
		sel = $urandom_range(99);
		if (sel < 60) begin
			l = $urandom_range(0, 63);
			t = $urandom_range(0, 31);
		end else if (sel < 85) begin
			l = $urandom_range(0, 639);
			t = $urandom_range(0, 479);
		end else if (sel < 93) begin
			l = $urandom_range(620, 645);
			t = $urandom_range(460, 485);
		end else begin
			l = $urandom_range(0, 65535);
			t = $urandom_range(0, 65535);
		end
		sel = $urandom_range(99);
		if (op == OP_SET_CLIP && sel < 50) begin
			w = $urandom_range(1, 200);
			h = $urandom_range(1, 200);
		end else if (sel < 88) begin
			w = $urandom_range(1, 16);
			h = $urandom_range(1, 16);
		end else if (sel < 90) begin
			w = $urandom_range(17, 48);
			h = $urandom_range(17, 48);
		end else if (sel < 94) begin
			w = $urandom_range(0, 1);
			h = $urandom_range(0, 1);
		end else begin
			w = $urandom_range(0, 65535);
			h = $urandom_range(0, 65535);
		end
		lvl = ($urandom_range(99) < 88) ? $urandom_range(0, 15) : $urandom_range(0, 255);
		issue(op, $urandom_range(99) < 90, $urandom_range(99) < 90, l, t, w, h, lvl,
			{$urandom, $urandom});
	endtask

	// Result side: random stalls, and one long hold-off while commands keep coming.
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && accepted_words >= 120) begin
				held = 1'b1;
				pop = 1'b0;
				repeat (300) @(negedge clk);
			end
			pop = no_gaps ? 1'b1 : ($urandom_range(99) >= 19);
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Refusals while drawing is not armed, after a clip clear, which is never refused.
		issue(OP_CLEAR_CLIP, 1'b0, 1'b0, 0, 0, 0, 0, 0, '0);
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 4, 4, 3, '0);
		issue(OP_READ, 1'b1, 1'b1, 0, 0, 0, 0, 0, '0);
		issue(OP_FILL, 1'b1, 1'b0, 0, 0, 4, 4, 3, '0);
		issue(OP_SET_CLIP, 1'b0, 1'b1, 0, 0, 4, 4, 0, '0);

		write_armed(1'b1);
		// Whole-panel fill and remap cut down to a small clip.
		issue(OP_SET_CLIP, 1'b1, 1'b1, 100, 50, 8, 4, 0, '0);
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 640, 480, 15, '0);
		issue(OP_REMAP, 1'b1, 1'b1, 0, 0, 640, 480, 0, 64'hfedc_ba98_7654_3210);
		issue(OP_REMAP, 1'b1, 1'b1, 96, 48, 8, 4, 0, 64'h0123_4567_89ab_cdef);
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 10, 10, 9, '0);
		issue(OP_READ, 1'b1, 1'b1, 103, 51, 0, 0, 0, '0);
		issue(OP_CLEAR_CLIP, 1'b1, 1'b1, 0, 0, 0, 0, 0, '0);
		// Bounds, level and operation-code refusals, and the far corner.
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 0, 5, 1, '0);
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 5, 0, 1, '0);
		issue(OP_FILL, 1'b1, 1'b1, 65535, 65535, 65535, 65535, 1, '0);
		issue(OP_REMAP, 1'b1, 1'b1, 0, 479, 1, 2, 0, '1);
		issue(OP_SET_CLIP, 1'b1, 1'b1, 639, 0, 2, 1, 0, '0);
		issue(OP_FILL, 1'b1, 1'b1, 639, 479, 1, 1, 7, '0);
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 2, 2, 16, '0);
		issue(OP_FILL, 1'b1, 1'b1, 0, 0, 2, 2, 255, '0);
		issue(OP_READ, 1'b1, 1'b1, 639, 479, 0, 0, 0, '0);
		issue(OP_READ, 1'b1, 1'b1, 640, 0, 0, 0, 0, '0);
		issue(OP_READ, 1'b1, 1'b1, 0, 480, 0, 0, 0, '0);
		issue(OP_READ, 1'b1, 1'b1, 65535, 65535, 0, 0, 0, '0);
		for (int op = 5; op < 8; op++) issue(3'(op), 1'b1, 1'b1, 0, 0, 1, 1, 0, '0);

		// Random commands, with a disarmed phase, a drain before each arming write and one more drain.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 200) write_armed(1'b0);
			if (n == 240) write_armed(1'b1);
			if (n == 350) drain();
			issue_random();
		end
		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- clipped_rect_fill_lut_engine_core.f -----
+incdir+src
src/crf_pkg.sv
src/crf_front.sv
src/crf_cmd_fifo.sv
src/crf_back.sv
src/clipped_rect_fill_lut_engine_core.sv
tb/clipped_rect_fill_lut_engine_checker.sv
tb/testbench.sv
